FILE: rtl/ets_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types and constants for the exhaustive tour search block.
// ----------------------------------------------------------------------------
package ets_pkg;

    localparam int COORD_W        = 10;
    localparam int COST_W         = 22;
    localparam int EDGE_W         = 19;
    localparam int RAD_W          = 2 * EDGE_W;
    localparam int MAX_CITIES_DEF = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    typedef struct packed {
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic               last_city;
    } ets_in_t;

    typedef struct packed {
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
        logic [COST_W-1:0]  tour_cost;
        logic               overflow;
        logic               last_segment;
    } ets_out_t;

    typedef struct packed {
        logic valid;
        logic full;
    } ets_q_stat_t;

    typedef struct packed {
        logic pop;
        logic idle;
    } ets_eng_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_SQUARE,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_COST,
        ST_COST_LAST,
        ST_CMP,
        ST_FIND_I,
        ST_FIND_J,
        ST_REVERSE,
        ST_OUT_FROM,
        ST_OUT_TO,
        ST_OUT_EMIT
    } ets_state_t;

endpackage
`default_nettype wire

FILE: rtl/ets_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ets_queue
// Short city queue between the input channel and the search engine.
// ----------------------------------------------------------------------------
module ets_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  ets_pkg::ets_in_t      push_data,
    input  wire                   push_valid,
    output logic                  push_ready,
    output ets_pkg::ets_in_t      pop_data,
    input  wire                   pop,
    output ets_pkg::ets_q_stat_t  stat
);
    import ets_pkg::*;

    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    ets_in_t         mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CNTW'(QUEUE_DEPTH));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign stat.valid = (count_reg != '0);
    assign stat.full  = !push_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ets_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ets_isqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ets_isqrt (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         start,
    input  wire  [ets_pkg::RAD_W-1:0]   radicand,
    output logic [ets_pkg::EDGE_W-1:0]  root,
    output logic                        done
);
    import ets_pkg::*;

    localparam int REM_W = EDGE_W + 3;
    localparam int CW    = $clog2(EDGE_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [EDGE_W-1:0] root_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign root   = root_reg;
    assign done   = done_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[EDGE_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(EDGE_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ets_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ets_engine
// Stores cities, builds the edge table, walks all tours and emits the best.
// ----------------------------------------------------------------------------
module ets_engine #(
    parameter int MAX_CITIES = ets_pkg::MAX_CITIES_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  ets_pkg::ets_in_t        in_data,
    input  ets_pkg::ets_q_stat_t    q_stat,
    output ets_pkg::ets_eng_stat_t  stat,
    output ets_pkg::ets_out_t       m_data,
    output logic                    m_valid,
    input  wire                     m_ready
);
    import ets_pkg::*;

    localparam int IW = $clog2(MAX_CITIES);
    localparam int CW = $clog2(MAX_CITIES + 1);
    localparam int TD = MAX_CITIES * MAX_CITIES;
    localparam int AW = $clog2(TD);

    ets_state_t state_reg, state_next;

    logic [COORD_W-1:0] city_x_mem [MAX_CITIES];
    logic [COORD_W-1:0] city_y_mem [MAX_CITIES];
    logic [EDGE_W-1:0]  edge_mem   [TD];

    logic [CW-1:0]      count_reg;
    logic               dropped_reg;
    logic [COORD_W-1:0] rd_x_reg, rd_y_reg;
    logic [EDGE_W-1:0]  edge_rd_reg;
    logic [IW-1:0]      a_reg, b_reg;
    logic [COORD_W-1:0] xa_reg, ya_reg;
    logic [2*COORD_W-1:0] sqx_reg, sqy_reg;
    logic [IW-1:0]      cur_reg  [MAX_CITIES];
    logic [IW-1:0]      best_reg [MAX_CITIES];
    logic [COST_W-1:0]  best_cost_reg;
    logic               have_best_reg;
    logic [COST_W-1:0]  sum_reg;
    logic               acc_valid_reg;
    logic [CW-1:0]      k_reg;
    logic [IW-1:0]      i_reg, j_reg, lo_reg, hi_reg;
    logic [COORD_W-1:0] from_x_reg, from_y_reg;
    ets_out_t           out_reg;
    logic               m_valid_reg;

    logic [IW-1:0]      city_rd_addr;
    logic [AW-1:0]      edge_rd_addr;
    logic [AW-1:0]      edge_wr_addr;
    logic               pop;
    logic               sq_start;
    logic               out_load;
    logic [IW-1:0]      k_idx;
    logic [IW-1:0]      k_nxt;
    logic               k_last;
    logic               pair_last;
    logic [COORD_W-1:0] dx, dy;
    logic [RAD_W-1:0]   radicand;
    logic [EDGE_W-1:0]  root;
    logic               sq_done;
    logic [COST_W:0]    sum_wide;

    assign k_idx     = k_reg[IW-1:0];
    assign k_last    = (k_reg == count_reg - 1'b1);
    assign k_nxt     = k_last ? '0 : k_idx + 1'b1;
    assign pair_last = (CW'(a_reg) == count_reg - 1'b1) && (CW'(b_reg) == count_reg - 1'b1);
    assign dx        = (xa_reg > rd_x_reg) ? xa_reg - rd_x_reg : rd_x_reg - xa_reg;
    assign dy        = (ya_reg > rd_y_reg) ? ya_reg - rd_y_reg : rd_y_reg - ya_reg;
    assign radicand  = RAD_W'({({1'b0, sqx_reg} + {1'b0, sqy_reg}), 16'h0000});
    assign edge_wr_addr = AW'(a_reg) * AW'(MAX_CITIES) + AW'(b_reg);
    assign sum_wide  = {1'b0, sum_reg} + (COST_W + 1)'(edge_rd_reg);

    ets_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (radicand),
        .root     (root),
        .done     (sq_done)
    );

    always_comb begin
        state_next   = state_reg;
        pop          = 1'b0;
        sq_start     = 1'b0;
        out_load     = 1'b0;
        city_rd_addr = a_reg;
        edge_rd_addr = AW'(cur_reg[k_idx]) * AW'(MAX_CITIES) + AW'(cur_reg[k_nxt]);
        unique case (state_reg)
            ST_IDLE: begin
                if (q_stat.valid) begin
                    pop = 1'b1;
                    if (in_data.last_city) begin
                        state_next = ST_RD_A;
                    end
                end
            end
            ST_RD_A: begin
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                city_rd_addr = b_reg;
                state_next   = ST_SQUARE;
            end
            ST_SQUARE: begin
                state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO: begin
                sq_start   = 1'b1;
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT: begin
                if (sq_done) begin
                    state_next = pair_last ? ST_COST : ST_RD_A;
                end
            end
            ST_COST: begin
                if (k_last) begin
                    state_next = ST_COST_LAST;
                end
            end
            ST_COST_LAST: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = (count_reg >= CW'(3)) ? ST_FIND_I : ST_OUT_FROM;
            end
            ST_FIND_I: begin
                if (cur_reg[i_reg] >= cur_reg[i_reg + 1'b1]) begin
                    if (i_reg == IW'(1)) begin
                        state_next = ST_OUT_FROM;
                    end
                end else begin
                    state_next = ST_FIND_J;
                end
            end
            ST_FIND_J: begin
                if (cur_reg[j_reg] > cur_reg[i_reg]) begin
                    state_next = ST_REVERSE;
                end
            end
            ST_REVERSE: begin
                if (lo_reg >= hi_reg) begin
                    state_next = ST_COST;
                end
            end
            ST_OUT_FROM: begin
                city_rd_addr = best_reg[k_idx];
                state_next   = ST_OUT_TO;
            end
            ST_OUT_TO: begin
                city_rd_addr = best_reg[k_nxt];
                state_next   = ST_OUT_EMIT;
            end
            ST_OUT_EMIT: begin
                // hold the read address so the end city stays on the read port
                city_rd_addr = best_reg[k_nxt];
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = k_last ? ST_IDLE : ST_OUT_FROM;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // memories: registered reads
    always_ff @(posedge aclk) begin
        if (pop && (count_reg < CW'(MAX_CITIES))) begin
            city_x_mem[count_reg[IW-1:0]] <= in_data.x_coord;
            city_y_mem[count_reg[IW-1:0]] <= in_data.y_coord;
        end
        rd_x_reg <= city_x_mem[city_rd_addr];
        rd_y_reg <= city_y_mem[city_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_ROOT_WAIT) && sq_done) begin
            edge_mem[edge_wr_addr] <= root;
        end
        edge_rd_reg <= edge_mem[edge_rd_addr];
    end

    // datapath without reset
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD_B) begin
            xa_reg <= rd_x_reg;
            ya_reg <= rd_y_reg;
        end
        if (state_reg == ST_SQUARE) begin
            sqx_reg <= dx * dx;
            sqy_reg <= dy * dy;
        end
        if (state_reg == ST_OUT_TO) begin
            from_x_reg <= rd_x_reg;
            from_y_reg <= rd_y_reg;
        end
        if (out_load) begin
            out_reg.from_x       <= from_x_reg;
            out_reg.from_y       <= from_y_reg;
            out_reg.to_x         <= rd_x_reg;
            out_reg.to_y         <= rd_y_reg;
            out_reg.tour_cost    <= best_cost_reg;
            out_reg.overflow     <= dropped_reg;
            out_reg.last_segment <= k_last;
        end
        if (acc_valid_reg) begin
            sum_reg <= sum_wide[COST_W] ? COST_MAX : sum_wide[COST_W-1:0];
        end else if (state_next == ST_COST && state_reg != ST_COST) begin
            sum_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            best_cost_reg <= COST_MAX;
            have_best_reg <= 1'b0;
            acc_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            for (int q = 0; q < MAX_CITIES; q++) begin
                cur_reg[q]  <= IW'(q);
                best_reg[q] <= IW'(q);
            end
        end else begin
            acc_valid_reg <= (state_reg == ST_COST);
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end else if (out_load) begin
                m_valid_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        if (count_reg < CW'(MAX_CITIES)) begin
                            count_reg <= count_reg + 1'b1;
                        end else begin
                            dropped_reg <= 1'b1;
                        end
                        a_reg <= '0;
                        b_reg <= '0;
                    end
                end
                ST_ROOT_WAIT: begin
                    if (sq_done) begin
                        // advance to the next city pair, start tour costing after the last
                        if (CW'(b_reg) == count_reg - 1'b1) begin
                            b_reg <= '0;
                            a_reg <= a_reg + 1'b1;
                        end else begin
                            b_reg <= b_reg + 1'b1;
                        end
                        k_reg <= '0;
                    end
                end
                ST_COST: begin
                    if (!k_last) begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_CMP: begin
                    if (!have_best_reg || (sum_reg < best_cost_reg)) begin
                        best_cost_reg <= sum_reg;
                        have_best_reg <= 1'b1;
                        for (int q = 0; q < MAX_CITIES; q++) begin
                            best_reg[q] <= cur_reg[q];
                        end
                    end
                    i_reg <= IW'(count_reg - CW'(2));
                    k_reg <= '0;
                end
                ST_FIND_I: begin
                    if (cur_reg[i_reg] >= cur_reg[i_reg + 1'b1]) begin
                        i_reg <= i_reg - 1'b1;
                    end else begin
                        j_reg <= IW'(count_reg - 1'b1);
                    end
                end
                ST_FIND_J: begin
                    if (cur_reg[j_reg] > cur_reg[i_reg]) begin
                        cur_reg[i_reg] <= cur_reg[j_reg];
                        cur_reg[j_reg] <= cur_reg[i_reg];
                        lo_reg         <= i_reg + 1'b1;
                        hi_reg         <= IW'(count_reg - 1'b1);
                    end else begin
                        j_reg <= j_reg - 1'b1;
                    end
                end
                ST_REVERSE: begin
                    if (lo_reg < hi_reg) begin
                        cur_reg[lo_reg] <= cur_reg[hi_reg];
                        cur_reg[hi_reg] <= cur_reg[lo_reg];
                        lo_reg          <= lo_reg + 1'b1;
                        hi_reg          <= hi_reg - 1'b1;
                    end else begin
                        k_reg <= '0;
                    end
                end
                ST_OUT_EMIT: begin
                    if (out_load) begin
                        if (k_last) begin
                            // batch done: return to the empty state
                            count_reg     <= '0;
                            dropped_reg   <= 1'b0;
                            best_cost_reg <= COST_MAX;
                            have_best_reg <= 1'b0;
                            k_reg         <= '0;
                            for (int q = 0; q < MAX_CITIES; q++) begin
                                cur_reg[q]  <= IW'(q);
                                best_reg[q] <= IW'(q);
                            end
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign stat.pop  = pop;
    assign stat.idle = (state_reg == ST_IDLE);
    assign m_data    = out_reg;
    assign m_valid   = m_valid_reg;

endmodule
`default_nettype wire

FILE: rtl/exhaustive_tour_search_top.sv
`default_nettype none
// Loading: one city per cycle through a two-entry queue while the engine is idle; no result for inner cities.
// Search for n cities: the edge table is built over all n*n city pairs with the square root unit,
// then each tour is costed on the edge memory port and followed by permutation steps;
// emitted segments wait on m_ready. Eight cities: 5040 tours. One batch in work at a time.
// Reset (aresetn, synchronous, low): empty city list, empty queue, no result pending.
// ----------------------------------------------------------------------------
// exhaustive_tour_search_top
// Brute-force shortest closed tour over the loaded cities.
// ----------------------------------------------------------------------------
module exhaustive_tour_search_top #(
    parameter int MAX_CITIES = ets_pkg::MAX_CITIES_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  ets_pkg::ets_in_t   s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output ets_pkg::ets_out_t  m_data
);
    import ets_pkg::*;

    ets_in_t       q_data;
    ets_q_stat_t   q_stat;
    ets_eng_stat_t eng_stat;

    ets_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_data  (s_data),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .pop_data   (q_data),
        .pop        (eng_stat.pop),
        .stat       (q_stat)
    );

    ets_engine #(
        .MAX_CITIES (MAX_CITIES)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_data (q_data),
        .q_stat  (q_stat),
        .stat    (eng_stat),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

    a_pop_when_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        eng_stat.pop |-> eng_stat.idle)
        else $error("queue popped while search busy");

    a_pop_needs_item : assert property (@(posedge aclk) disable iff (!aresetn)
        eng_stat.pop |-> q_stat.valid)
        else $error("queue popped while empty");

    a_full_blocks : assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !s_ready)
        else $error("input ready while queue full");

endmodule
`default_nettype wire

FILE: sim/exhaustive_tour_search_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exhaustive_tour_search_top_test
// Loads batches of cities, predicts the cheapest closed tour in software and
// checks every emitted segment against it, under random sender and receiver
// idling.
// ----------------------------------------------------------------------------
module exhaustive_tour_search_top_test;
    import ets_pkg::*;

    localparam int NCITY = MAX_CITIES_DEF;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    ets_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    ets_out_t m_data;

    exhaustive_tour_search_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // predictor state
    logic [COORD_W-1:0] city_x [NCITY];
    logic [COORD_W-1:0] city_y [NCITY];
    int unsigned        loaded_count;
    logic               dropped;
    logic [EDGE_W-1:0]  edge_len [NCITY][NCITY];

    ets_out_t    segment_queue[$];
    int unsigned mismatch_count;
    int unsigned segments_seen;
    int unsigned batches_sent;
    int unsigned cities_sent;
    int unsigned burst_left;
    bit          stall_pattern [16];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [EDGE_W-1:0] root_of(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 38;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[EDGE_W-1:0];
    endfunction

    function automatic int unsigned cost_of(int unsigned ord[NCITY], int unsigned n);
        int unsigned sum;
        int unsigned b;
        sum = 0;
        for (int k = 0; k < n; k++) begin
            b = (k + 1 == n) ? ord[0] : ord[k + 1];
            sum += edge_len[ord[k]][b];
            if (sum > COST_MAX) sum = COST_MAX;
        end
        return sum;
    endfunction

    function automatic bit advance_order(ref int unsigned ord[NCITY], input int unsigned n);
        int i;
        int j;
        int unsigned t;
        if (n < 3) return 0;
        i = n - 2;
        while (i >= 1 && ord[i] >= ord[i + 1]) i--;
        if (i < 1) return 0;
        j = n - 1;
        while (ord[j] <= ord[i]) j--;
        t = ord[i]; ord[i] = ord[j]; ord[j] = t;
        j = i + 1;
        i = n - 1;
        while (j < i) begin
            t = ord[j]; ord[j] = ord[i]; ord[i] = t;
            j++; i--;
        end
        return 1;
    endfunction

    // Store one city; on the last one, run the full search and queue segments.
    task automatic predict_city(ets_in_t c);
        int unsigned cur [NCITY];
        int unsigned best [NCITY];
        int unsigned best_cost;
        int unsigned cost;
        int unsigned n;
        int unsigned dx;
        int unsigned dy;
        int unsigned t;
        ets_out_t seg;
        if (loaded_count < NCITY) begin
            city_x[loaded_count] = c.x_coord;
            city_y[loaded_count] = c.y_coord;
            loaded_count++;
        end else begin
            dropped = 1'b1;
        end
        if (!c.last_city) return;
        n = loaded_count;
        for (int a = 0; a < n; a++)
            for (int b = 0; b < n; b++) begin
                dx = city_x[a] > city_x[b] ? city_x[a] - city_x[b] : city_x[b] - city_x[a];
                dy = city_y[a] > city_y[b] ? city_y[a] - city_y[b] : city_y[b] - city_y[a];
                edge_len[a][b] = root_of(longint'(dx * dx + dy * dy) << 16);
            end
        for (int i = 0; i < NCITY; i++) begin
            cur[i] = i;
            best[i] = i;
        end
        best_cost = cost_of(cur, n);
        while (advance_order(cur, n)) begin
            cost = cost_of(cur, n);
            if (cost < best_cost) begin
                best_cost = cost;
                best = cur;
            end
        end
        for (int k = 0; k < n; k++) begin
            t = (k + 1 == n) ? best[0] : best[k + 1];
            seg.from_x = city_x[best[k]];
            seg.from_y = city_y[best[k]];
            seg.to_x = city_x[t];
            seg.to_y = city_y[t];
            seg.tour_cost = best_cost[COST_W-1:0];
            seg.overflow = dropped;
            seg.last_segment = (k + 1 == n);
            segment_queue = {segment_queue, seg};
        end
        loaded_count = 0;
        dropped = 1'b0;
        batches_sent++;
    endtask

    // Send one transaction, with a random gap between bursts.
    task automatic send_city(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_data.x_coord = x;
        s_data.y_coord = y;
        s_data.last_city = last;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_city(s_data);
        cities_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_batch(int unsigned n);
        for (int i = 0; i < n; i++)
            send_city(COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)),
                      i == n - 1);
    endtask

    // Receiver stalls follow a repeating random pattern, refreshed now and then.
    initial begin
        int unsigned phase;
        phase = 0;
        for (int i = 0; i < 16; i++) stall_pattern[i] = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            phase = (phase + 1) % 16;
            if (phase == 0 && $urandom_range(0, 3) == 0)
                for (int i = 0; i < 16; i++) stall_pattern[i] = $urandom_range(0, 2) == 0;
            m_ready = !stall_pattern[phase];
        end
    end

    // Compare each segment against the oldest expectation.
    always @(posedge aclk) begin
        ets_out_t want;
        if (aresetn && m_valid && m_ready) begin
            segments_seen++;
            if (segment_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected segment %p", m_data);
            end else begin
                want = segment_queue.pop_front();
                if (m_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("segment mismatch: expected %p actual %p", want, m_data);
                end
            end
        end
    end

    task automatic test_extremes();
        send_city(10'd0, 10'd0, 1'b1);             // single city
        send_city(10'd0, 10'd0, 1'b0);
        send_city(10'd1023, 10'd1023, 1'b1);
        send_city(10'd1023, 10'd0, 1'b0);
        send_city(10'd0, 10'd1023, 1'b0);
        send_city(10'd1023, 10'd1023, 1'b0);
        send_city(10'd0, 10'd0, 1'b1);
        // equal cities make every tour tie
        for (int i = 0; i < 4; i++) send_city(10'd341, 10'd682, i == 3);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < NCITY + 2; i++)
            send_city(i[0] ? 10'd1023 : 10'd0, COORD_W'((i * 97) % 1024), i == NCITY + 1);
    endtask

    task automatic test_random();
        int unsigned n;
        while (cities_sent < 105) begin
            n = $urandom_range(0, 9) == 0 ? $urandom_range(7, 9) : $urandom_range(1, 6);
            send_batch(n);
        end
    endtask

    initial begin
        s_valid = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        loaded_count = 0;
        dropped = 1'b0;
        mismatch_count = 0;
        segments_seen = 0;
        batches_sent = 0;
        cities_sent = 0;
        burst_left = 0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_extremes();
        test_overflow();
        test_random();
        while (segment_queue.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        $display("sent %0d cities in %0d batches, checked %0d tour segments",
                 cities_sent, batches_sent, segments_seen);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("timeout with %0d segments outstanding", segment_queue.size());
        $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: exhaustive_tour_search_top.f
rtl/ets_pkg.sv
rtl/ets_queue.sv
rtl/ets_isqrt.sv
rtl/ets_engine.sv
rtl/exhaustive_tour_search_top.sv
sim/exhaustive_tour_search_top_test.sv
